FILE: rtl/double_ended_queue_macros.svh
// Assertion macros shared by the double-ended queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/dq_pkg.sv
// Package for the double-ended queue: payload structs, command and status codes.
// Depends on nothing; used by dq_cell and double_ended_queue.
package dq_pkg;

	localparam int DQ_DEPTH = 16;
	localparam int DQ_DATA_W = 32;

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_QUERY      = 3'd4;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_LOAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0]                  cmd;
		logic signed [DQ_DATA_W-1:0] push_value;
	} in_t;

	typedef struct packed {
		logic signed [DQ_DATA_W-1:0] front_value;
		logic signed [DQ_DATA_W-1:0] back_value;
		logic [4:0]                  item_count;
		logic                        is_empty;
		logic [1:0]                  status;
	} out_t;

endpackage

FILE: rtl/dq_cell.sv
// One storage cell of the queue chain: holds a value, takes its left or right
// neighbor's value on a shift, or loads the pushed value. Depends on dq_pkg.
module dq_cell (
	input  logic                         clk,
	input  dq_pkg::cell_ctl_t            ctl,
	input  logic [dq_pkg::DQ_DATA_W-1:0] left_data,
	input  logic [dq_pkg::DQ_DATA_W-1:0] right_data,
	input  logic [dq_pkg::DQ_DATA_W-1:0] load_data,
	output logic [dq_pkg::DQ_DATA_W-1:0] data
);
	import dq_pkg::*;

	logic [DQ_DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_HOLD:       data_q <= data_q;
			CELL_FROM_LEFT:  data_q <= left_data;
			CELL_FROM_RIGHT: data_q <= right_data;
			CELL_LOAD:       data_q <= load_data;
			default:         data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

FILE: rtl/double_ended_queue.sv
// Top level of the double-ended queue: a row of dq_cell stages with the front
// at cell 0, the count register and the output register. Depends on dq_pkg.
//
// The queue keeps its values in a row of DEPTH cells, front value in cell 0.
// A push or pop at the front shifts the whole row by one place; a push at the
// back writes the cell just past the last value and a pop at the back only
// lowers the count. Every command, including a no-op query, produces exactly
// one result carrying the front value, back value, count, empty flag and
// status; front and back read as all ones when the queue is empty. A push
// into a full queue and a pop from an empty one leave the contents unchanged
// and report it in the status field. The block takes one command per clock
// cycle while no result waits or out_ready is high: the single output register
// sets that figure, and a new command is taken in the same cycle that the
// previous result is transferred. There is no clearing pass after reset.
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  dq_pkg::in_t  in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output dq_pkg::out_t out_data
);
	import dq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_next;
	logic                 out_valid_q;
	out_t                 out_q;
	out_t                 out_next;
	logic                 accept;
	logic                 full;
	logic                 empty;
	logic                 do_push_front;
	logic                 do_push_back;
	logic                 do_pop_front;
	logic                 do_pop_back;
	logic [1:0]           status;
	logic [DQ_DATA_W-1:0] back_last;
	logic [DQ_DATA_W-1:0] back_prev;
	logic [DQ_DATA_W-1:0] front_next;
	logic [DQ_DATA_W-1:0] back_next;
	logic [CW+4:0]        count_ext;
	logic [DQ_DATA_W-1:0] cell_data [DEPTH];
	cell_ctl_t            cell_ctl  [DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		do_push_front = 1'b0;
		do_push_back  = 1'b0;
		do_pop_front  = 1'b0;
		do_pop_back   = 1'b0;
		status        = STATUS_DONE;
		unique case (in_data.cmd)
			CMD_PUSH_FRONT: begin
				if (full) status = STATUS_FULL;
				else do_push_front = 1'b1;
			end
			CMD_PUSH_BACK: begin
				if (full) status = STATUS_FULL;
				else do_push_back = 1'b1;
			end
			CMD_POP_FRONT: begin
				if (empty) status = STATUS_EMPTY;
				else do_pop_front = 1'b1;
			end
			CMD_POP_BACK: begin
				if (empty) status = STATUS_EMPTY;
				else do_pop_back = 1'b1;
			end
			default: status = STATUS_DONE;
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DQ_DATA_W-1:0] left_data;
		logic [DQ_DATA_W-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = in_data.push_value;
		end else begin : g_inner
			assign left_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_mid
			assign right_data = cell_data[i+1];
		end

		always_comb begin
			cell_ctl[i].op = CELL_HOLD;
			if (accept) begin
				priority if (do_push_front) begin
					cell_ctl[i].op = CELL_FROM_LEFT;
				end else if (do_pop_front) begin
					cell_ctl[i].op = CELL_FROM_RIGHT;
				end else if (do_push_back && count_q == CW'(i)) begin
					cell_ctl[i].op = CELL_LOAD;
				end else begin
					cell_ctl[i].op = CELL_HOLD;
				end
			end
		end

		dq_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.left_data  (left_data),
			.right_data (right_data),
			.load_data  (in_data.push_value),
			.data       (cell_data[i])
		);
	end

	always_comb begin
		back_last = '0;
		back_prev = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (count_q == CW'(i + 1)) back_last = back_last | cell_data[i];
			if ((i + 2 <= DEPTH) && (count_q == CW'(i + 2))) begin
				back_prev = back_prev | cell_data[i];
			end
		end
	end

	always_comb begin
		count_next = count_q;
		front_next = cell_data[0];
		back_next  = back_last;
		priority if (do_push_front) begin
			count_next = count_q + CW'(1);
			front_next = in_data.push_value;
			back_next  = empty ? in_data.push_value : back_last;
		end else if (do_push_back) begin
			count_next = count_q + CW'(1);
			front_next = empty ? in_data.push_value : cell_data[0];
			back_next  = in_data.push_value;
		end else if (do_pop_front) begin
			count_next = count_q - CW'(1);
			front_next = cell_data[1];
		end else if (do_pop_back) begin
			count_next = count_q - CW'(1);
			back_next  = back_prev;
		end else begin
			count_next = count_q;
		end
		if (count_next == '0) begin
			front_next = '1;
			back_next  = '1;
		end
		count_ext            = {5'd0, count_next};
		out_next.front_value = front_next;
		out_next.back_value  = back_next;
		out_next.item_count  = count_ext[4:0];
		out_next.is_empty    = (count_next == '0);
		out_next.status      = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) out_q <= out_next;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`DQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "count above depth")
	`DQ_ASSERT_NOW(a_empty_flag, clk, arst_n, out_valid_q,
		out_q.is_empty == (count_q == '0), "empty flag disagrees with count")
	`DQ_ASSERT_NOW(a_empty_reads, clk, arst_n, out_valid_q && out_q.is_empty,
		(out_q.front_value == '1) && (out_q.back_value == '1), "empty queue must read all ones")
	`DQ_ASSERT_NEXT(a_full_drop, clk, arst_n,
		accept && full && (in_data.cmd == CMD_PUSH_FRONT || in_data.cmd == CMD_PUSH_BACK),
		out_q.status == STATUS_FULL && count_q == $past(count_q), "push on full not dropped")
	`DQ_ASSERT_NEXT(a_pop_count, clk, arst_n, accept && (do_pop_front || do_pop_back),
		count_q == $past(count_q) - CW'(1), "pop did not lower count")

endmodule
